// ===== hw/rtl/sdiv_pkg.sv =====
package sdiv_pkg;

	// Operand and result widths
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 32;
	localparam int RESULT_W   = 32;

	// Quotient bits resolved by each divider stage (must divide RESULT_W)
	localparam int STEPS_PER_STAGE_DEF = 2;

	// Status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	// Saturated quotient magnitude and its negation
	localparam logic [RESULT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [RESULT_W-1:0] SAT_NEG = 32'h8000_0001;

	// Side information that rides along with each request
	typedef struct packed {
		logic       qneg;
		logic       xneg;
		logic [1:0] status;
	} ctl_t;

	// Working set of one divider stage: partial remainder, dividend low
	// word that turns into the quotient, divisor magnitude
	typedef struct packed {
		logic [RESULT_W-1:0]  rem;
		logic [RESULT_W-1:0]  lo;
		logic [DIVISOR_W-1:0] ay;
	} work_t;

endpackage

// ===== hw/rtl/sdiv_prep.sv =====
module sdiv_prep
	import sdiv_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic signed [DIVISOR_W-1:0]  divisor,
	output logic                         valid_out,
	output ctl_t                         ctl_out,
	output work_t                        work_out
);

	logic                  valid_s1;
	logic [DIVIDEND_W-1:0] ax_s1;
	logic [DIVISOR_W-1:0]  ay_s1;
	logic                  xneg_s1;
	logic                  yneg_s1;

	logic                  valid_s2;
	ctl_t                  ctl_s2;
	work_t                 work_s2;

	logic [DIVIDEND_W-1:0] ay_shl;
	logic                  dz;
	logic                  ovf;
	logic [1:0]            st;

	// Stage 1: magnitudes of both operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xneg_s1 <= dividend[DIVIDEND_W-1];
			yneg_s1 <= divisor[DIVISOR_W-1];
			ax_s1   <= dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
			ay_s1   <= divisor[DIVISOR_W-1] ? (~divisor + 1'b1) : divisor;
		end
	end

	// Stage 2: classify (divide by zero, overflow)
	assign ay_shl = {1'b0, ay_s1, {(DIVIDEND_W-DIVISOR_W-1){1'b0}}};
	assign dz     = (ay_s1 == '0);
	assign ovf    = (ax_s1 >= ay_shl);

	always_comb begin
		if (dz) begin
			st = ST_DZ;
		end else if (ovf) begin
			st = ST_OVF;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.qneg   <= xneg_s1 ^ yneg_s1;
			ctl_s2.xneg   <= xneg_s1;
			ctl_s2.status <= st;
			work_s2.rem   <= ax_s1[DIVIDEND_W-1:RESULT_W];
			work_s2.lo    <= ax_s1[RESULT_W-1:0];
			work_s2.ay    <= ay_s1;
		end
	end

	assign valid_out = valid_s2;
	assign ctl_out   = ctl_s2;
	assign work_out  = work_s2;

endmodule

// ===== hw/rtl/sdiv_stage.sv =====
module sdiv_stage
	import sdiv_pkg::*;
#(
	parameter int STEPS = STEPS_PER_STAGE_DEF
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  ctl_t  ctl_in,
	input  work_t work_in,
	output logic  valid_out,
	output ctl_t  ctl_out,
	output work_t work_out
);

	logic  valid_s1;
	ctl_t  ctl_s1;
	work_t work_s1;
	work_t work_nxt;

	// Restoring division, STEPS quotient bits: shift in the next dividend
	// bit, subtract the divisor when it fits, shift the quotient bit in
	always_comb begin
		logic [RESULT_W:0]   trial;
		logic [RESULT_W:0]   diff;
		logic [RESULT_W-1:0] rem;
		logic [RESULT_W-1:0] lo;
		rem = work_in.rem;
		lo  = work_in.lo;
		for (int i = 0; i < STEPS; i++) begin
			trial = {rem, lo[RESULT_W-1]};
			diff  = trial - {1'b0, work_in.ay};
			if (!diff[RESULT_W]) begin
				rem = diff[RESULT_W-1:0];
				lo  = {lo[RESULT_W-2:0], 1'b1};
			end else begin
				rem = trial[RESULT_W-1:0];
				lo  = {lo[RESULT_W-2:0], 1'b0};
			end
		end
		work_nxt.rem = rem;
		work_nxt.lo  = lo;
		work_nxt.ay  = work_in.ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_in;
			work_s1 <= work_nxt;
		end
	end

	assign valid_out = valid_s1;
	assign ctl_out   = ctl_s1;
	assign work_out  = work_s1;

endmodule

// ===== hw/rtl/sdiv_fix.sv =====
module sdiv_fix
	import sdiv_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_in,
	input  ctl_t                       ctl_in,
	input  work_t                      work_in,
	output logic                       valid_out,
	output logic signed [RESULT_W-1:0] quotient,
	output logic signed [RESULT_W-1:0] remainder,
	output logic [1:0]                 status
);

	logic                valid_q;
	logic [RESULT_W-1:0] quot_q;
	logic [RESULT_W-1:0] rem_q;
	logic [1:0]          status_q;
	logic [RESULT_W-1:0] quot_nxt;
	logic [RESULT_W-1:0] rem_nxt;

	// Sign correction and special-case override
	always_comb begin
		case (ctl_in.status)
			ST_OK: begin
				quot_nxt = ctl_in.qneg ? (~work_in.lo + 1'b1) : work_in.lo;
				rem_nxt  = ctl_in.xneg ? (~work_in.rem + 1'b1) : work_in.rem;
			end
			ST_OVF: begin
				quot_nxt = ctl_in.qneg ? SAT_NEG : SAT_POS;
				rem_nxt  = '0;
			end
			default: begin
				quot_nxt = '0;
				rem_nxt  = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_q   <= quot_nxt;
			rem_q    <= rem_nxt;
			status_q <= ctl_in.status;
		end
	end

	assign valid_out = valid_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;
	assign status    = status_q;

endmodule

// ===== hw/rtl/signed_divide_64_by_32_saturating_core.sv =====
// Channel   Handshake              Payload
// request   div_valid / div_ready  dividend[63:0], divisor[31:0]
// result    res_valid / res_ready  quotient[31:0], remainder[31:0], status[1:0]
//
// One request accepted per cycle unless the result stalls; a request passes the
// prep registers, the chain of restoring divider stages and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline; div_ready drops only then.

module signed_divide_64_by_32_saturating_core
	import sdiv_pkg::*;
#(
	parameter int STEPS_PER_STAGE = STEPS_PER_STAGE_DEF
)
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         div_valid,
	output logic                         div_ready,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic signed [DIVISOR_W-1:0]  divisor,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic signed [RESULT_W-1:0]   quotient,
	output logic signed [RESULT_W-1:0]   remainder,
	output logic [1:0]                   status
);

	localparam int NSTAGES = RESULT_W / STEPS_PER_STAGE;

	logic  en;
	logic  valid_w [0:NSTAGES];
	ctl_t  ctl_w   [0:NSTAGES];
	work_t work_w  [0:NSTAGES];

	// Pipeline advances unless a finished result is waiting
	assign en        = !res_valid || res_ready;
	assign div_ready = en;

	sdiv_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (div_valid),
		.dividend  (dividend),
		.divisor   (divisor),
		.valid_out (valid_w[0]),
		.ctl_out   (ctl_w[0]),
		.work_out  (work_w[0])
	);

	// Divider stages
	for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
		sdiv_stage #(
			.STEPS (STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_w[g]),
			.ctl_in    (ctl_w[g]),
			.work_in   (work_w[g]),
			.valid_out (valid_w[g+1]),
			.ctl_out   (ctl_w[g+1]),
			.work_out  (work_w[g+1])
		);
	end

	sdiv_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_w[NSTAGES]),
		.ctl_in    (ctl_w[NSTAGES]),
		.work_in   (work_w[NSTAGES]),
		.valid_out (res_valid),
		.quotient  (quotient),
		.remainder (remainder),
		.status    (status)
	);

endmodule

// ===== hw/rtl/sdiv_checker.sv =====
module sdiv_checker
	import sdiv_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       div_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic signed [RESULT_W-1:0] quotient,
	input logic signed [RESULT_W-1:0] remainder,
	input logic [1:0]                 status
);

	// A stalled result keeps its valid
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// With no result pending, a request is always taken
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> div_ready)
		else $error("request refused with empty output");

	// Unused status code never shows
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status != 2'd3)
		else $error("undefined status");

	// Divide by zero gives zero results
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_DZ |-> quotient == '0 && remainder == '0)
		else $error("divide by zero results not zero");

	// Overflow saturates with zero remainder
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OVF |->
		remainder == '0 && (quotient == SAT_POS || quotient == SAT_NEG))
		else $error("overflow result not saturated");

endmodule

bind signed_divide_64_by_32_saturating_core sdiv_checker u_sdiv_checker (.*);
